FILE: sv/led_blink_morse_driver_core_assert.svh
// Assertion macros used by the keyer checker
`ifndef LED_BLINK_MORSE_DRIVER_CORE_ASSERT_SVH
`define LED_BLINK_MORSE_DRIVER_CORE_ASSERT_SVH

// clocked check, quiet while reset is held
`define LBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define LBM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/lbm_pkg.sv
// Shared constants, Morse tables and helpers for the LED keyer
package lbm_pkg;

  localparam int MSG_DEPTH_DEF = 64;
  localparam int TIME_BITS_DEF = 16;

  localparam int MODE_W     = 2;
  localparam int BLINK_W    = 15;
  localparam int DIT_W      = 14;
  localparam int DAH_W      = 16;
  localparam int DIT7_W     = 17;
  localparam int ELAPSED_W  = 16;
  localparam int CHAR_W     = 8;
  localparam int POS_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int PAT_W      = 6;
  localparam int SYM_W      = 3;

  localparam logic [MODE_W-1:0] MODE_FIXED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLINK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MORSE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_OFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIT       = 3'd4;

  localparam logic [DIT_W-1:0]  DIT_RESET  = 14'd100;
  localparam logic [DAH_W-1:0]  DAH_RESET  = 16'd300;
  localparam logic [DAH_W-1:0]  DIT4_RESET = 16'd400;
  localparam logic [DIT7_W-1:0] DIT7_RESET = 17'd700;

  localparam logic [PAT_W-1:0] PAUSE_CODE = 6'h01;
  localparam logic [PAT_W-1:0] WAIT_CODE  = 6'h28;

  // leading 1 then symbols, 1 = dah
  localparam logic [PAT_W-1:0] LETTER_CODES [26] = '{
    6'h05, 6'h18, 6'h1A, 6'h0C, 6'h02, 6'h12, 6'h0E, 6'h10, 6'h04, 6'h17, 6'h0D, 6'h14,
    6'h07, 6'h06, 6'h0F, 6'h16, 6'h1D, 6'h0A, 6'h08, 6'h03, 6'h09, 6'h11, 6'h0B, 6'h19,
    6'h1B, 6'h1C
  };
  localparam logic [PAT_W-1:0] DIGIT_CODES [10] = '{
    6'h3F, 6'h2F, 6'h27, 6'h23, 6'h21, 6'h20, 6'h30, 6'h38, 6'h3C, 6'h3E
  };

  function automatic logic [PAT_W-1:0] code_for(input logic [CHAR_W-1:0] c);
    logic [PAT_W-1:0] code;
    if (c inside {[8'h61:8'h7A]}) begin
      code = LETTER_CODES[5'(c - 8'h61)];
    end else if (c inside {[8'h41:8'h5A]}) begin
      code = LETTER_CODES[5'(c - 8'h41)];
    end else if (c inside {[8'h30:8'h39]}) begin
      code = DIGIT_CODES[4'(c - 8'h30)];
    end else if (c <= 8'd32 || c >= 8'd128) begin
      code = PAUSE_CODE;
    end else begin
      code = WAIT_CODE;
    end
    return code;
  endfunction

  // symbol count: position of the leading marker bit, at least one
  function automatic logic [SYM_W-1:0] sym_count(input logic [PAT_W-1:0] p);
    logic [SYM_W-1:0] n;
    n = SYM_W'(1);
    for (int i = 2; i < PAT_W; i++) begin
      if (p[i]) n = SYM_W'(i);
    end
    return n;
  endfunction

endpackage

FILE: sv/lbm_msg_store.sv
// Message character store with registered, write-forwarded prefetch read
module lbm_msg_store
  import lbm_pkg::*;
#(
  parameter int MSG_DEPTH = MSG_DEPTH_DEF,
  localparam int ADDR_W = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [CHAR_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [CHAR_W-1:0] rd_data,
  output logic [CHAR_W-1:0] head_data
);

  logic [CHAR_W-1:0] mem [MSG_DEPTH];
  logic [CHAR_W-1:0] rd_r;
  logic [CHAR_W-1:0] head_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && wr_addr == rd_addr) begin
      rd_r <= wr_data;
    end else begin
      rd_r <= mem[rd_addr];
    end
    if (wr_en && wr_addr == '0) begin
      head_r <= wr_data;
    end
  end

  assign rd_data   = rd_r;
  assign head_data = head_r;

endmodule

FILE: sv/led_blink_morse_driver_core.sv
// LED keyer top level: fixed level, blink and looping Morse playback
//
//   channel | signals                                         | direction
//   in      | in_valid/in_ready, kind, elapsed, character,    | in
//           | last_char                                       |
//   out     | out_valid/out_ready, led_on, char_position      | out
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data        | in
//
// One transaction per cycle: all state updates between the input handshake
// and the result register, so the result shows in the cycle after acceptance.
// A transaction is taken while the result register is empty or being drained.
// Synchronous active-low reset initialises all control state; cfg_ready is always
// high. The store keeps a prefetched copy of the next character to play.
module led_blink_morse_driver_core
  import lbm_pkg::*;
#(
  parameter int MSG_DEPTH = MSG_DEPTH_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [ELAPSED_W-1:0]  in_elapsed,
  input  logic [CHAR_W-1:0]     in_character,
  input  logic                  in_last_char,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_led_on,
  output logic [POS_W-1:0]      out_char_position,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
  localparam int CNT_W  = $clog2(MSG_DEPTH + 1);
  localparam int EXT_W  = ((TIME_BITS > 18) ? TIME_BITS : 18) + 1;
  localparam logic [EXT_W-1:0] TIME_MAX_EXT =
    {{(EXT_W - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MSG_DEPTH);

  function automatic logic [TIME_BITS-1:0] sat_t(input logic [EXT_W-1:0] v);
    return (v > TIME_MAX_EXT) ? {TIME_BITS{1'b1}} : v[TIME_BITS-1:0];
  endfunction

  // configuration
  logic [MODE_W-1:0]  mode_r;
  logic               fixed_r;
  logic [BLINK_W-1:0] blink_on_r;
  logic [BLINK_W-1:0] blink_off_r;
  logic [DIT_W-1:0]   dit_r;
  logic [DAH_W-1:0]   dah_r;
  logic [DAH_W-1:0]   dit4_r;
  logic [DIT7_W-1:0]  dit7_r;
  logic [DIT_W-1:0]   cfg_dit;

  // keyer state
  logic [TIME_BITS-1:0] tc_r, tc_nxt;
  logic                 led_r, led_nxt;
  logic [TIME_BITS-1:0] on_mark_r, on_mark_nxt;
  logic [TIME_BITS-1:0] off_mark_r, off_mark_nxt;
  logic [PAT_W-1:0]     pat_r, pat_nxt;
  logic [SYM_W-1:0]     sl_r, sl_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     rp_r, rp_nxt;
  logic [CNT_W-1:0]     wp_r, wp_nxt;

  logic                 out_valid_r;
  logic                 out_led_r;
  logic [POS_W-1:0]     out_pos_r;
  logic [CNT_W+POS_W-1:0] wp_ext;

  // store port
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [CHAR_W-1:0] rd_data;
  logic [CHAR_W-1:0] head_data;

  // datapath temporaries
  logic                 accept;
  logic                 timed_mode;
  logic [CNT_W-1:0]     tick_pos;
  logic [CHAR_W-1:0]    tick_char;
  logic [CHAR_W-1:0]    load_char;
  logic [CNT_W-1:0]     load_cnt;
  logic [TIME_BITS-1:0] tc_a;
  logic [TIME_BITS-1:0] on_m, off_m;
  logic [PAT_W-1:0]     np_pat, ld_pat;
  logic [SYM_W-1:0]     np_sl1, np_sl;
  logic [CNT_W-1:0]     np_rp;
  logic                 np_pause;
  logic [EXT_W-1:0]     np_on_raw, np_gap;
  logic [TIME_BITS-1:0] np_on, np_off;

  assign accept     = in_valid && in_ready;
  assign in_ready   = rst_n && (!out_valid_r || out_ready);
  assign cfg_ready  = 1'b1;
  assign cfg_dit    = cfg_data[DIT_W-1:0];
  assign timed_mode = (mode_r == MODE_BLINK) || (mode_r == MODE_MORSE);

  lbm_msg_store #(
    .MSG_DEPTH (MSG_DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_character),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .head_data (head_data)
  );

  always_comb begin
    // fetch sources
    tick_pos  = (rp_r >= cnt_r) ? '0 : rp_r;
    tick_char = (cnt_r != '0) ? rd_data : '0;
    load_cnt  = (wp_r < DEPTH_C) ? (wp_r + CNT_W'(1)) : wp_r;
    load_char = (wp_r == '0) ? in_character : head_data;
    ld_pat    = code_for(load_char);

    // tick: accumulate and reload blink marks
    tc_a  = sat_t(EXT_W'(tc_r) + EXT_W'(in_elapsed));
    on_m  = on_mark_r;
    off_m = off_mark_r;
    if (mode_r == MODE_BLINK) begin
      on_m  = sat_t(EXT_W'(blink_on_r));
      off_m = sat_t(EXT_W'(blink_on_r) + EXT_W'(blink_off_r));
    end

    // next Morse pulse
    if (sl_r == '0) begin
      np_pat = code_for(tick_char);
      np_sl1 = sym_count(np_pat);
      np_rp  = tick_pos + CNT_W'(1);
    end else begin
      np_pat = pat_r;
      np_sl1 = sl_r;
      np_rp  = rp_r;
    end
    np_sl     = np_sl1 - SYM_W'(1);
    np_pause  = (np_pat == PAUSE_CODE);
    np_on_raw = np_pat[np_sl] ? EXT_W'(dah_r) : EXT_W'(dit_r);
    if (np_sl != '0) begin
      np_gap = EXT_W'(dit_r);
    end else if (np_rp < cnt_r) begin
      np_gap = EXT_W'(dah_r);
    end else begin
      np_gap = EXT_W'(dit7_r);
    end
    np_on  = np_pause ? '0 : sat_t(np_on_raw);
    np_off = np_pause ? sat_t(EXT_W'(dit4_r)) : sat_t(np_on_raw + np_gap);

    tc_nxt       = tc_r;
    led_nxt      = led_r;
    on_mark_nxt  = on_mark_r;
    off_mark_nxt = off_mark_r;
    pat_nxt      = pat_r;
    sl_nxt       = sl_r;
    cnt_nxt      = cnt_r;
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    wr_en        = 1'b0;
    wr_addr      = wp_r[ADDR_W-1:0];

    if (accept) begin
      if (!in_kind) begin
        tc_nxt = tc_a;
        if (timed_mode) begin
          on_mark_nxt  = on_m;
          off_mark_nxt = off_m;
          if (!led_r) begin
            if (tc_a >= off_m) begin
              tc_nxt = '0;
              if (mode_r == MODE_MORSE) begin
                pat_nxt      = np_pat;
                sl_nxt       = np_sl;
                rp_nxt       = np_rp;
                on_mark_nxt  = np_on;
                off_mark_nxt = np_off;
                if (np_on != '0) led_nxt = 1'b1;
              end else if (on_m != '0) begin
                led_nxt = 1'b1;
              end
            end else if (tc_a < on_m) begin
              led_nxt = 1'b1;
            end
          end else if (tc_a >= on_m) begin
            led_nxt = 1'b0;
          end
        end
      end else begin
        if (wp_r < DEPTH_C) begin
          wr_en  = 1'b1;
          wp_nxt = wp_r + CNT_W'(1);
        end
        if (in_last_char) begin
          cnt_nxt = load_cnt;
          wp_nxt  = '0;
          rp_nxt  = CNT_W'(1);
          pat_nxt = ld_pat;
          sl_nxt  = sym_count(ld_pat);
        end
      end
      if (!timed_mode) led_nxt = fixed_r;
    end

    rd_addr = (rp_nxt >= cnt_nxt) ? '0 : rp_nxt[ADDR_W-1:0];
    wp_ext  = {{POS_W{1'b0}}, wp_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_FIXED;
      fixed_r     <= 1'b0;
      blink_on_r  <= '0;
      blink_off_r <= '0;
      dit_r       <= DIT_RESET;
      dah_r       <= DAH_RESET;
      dit4_r      <= DIT4_RESET;
      dit7_r      <= DIT7_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:      mode_r      <= cfg_data[MODE_W-1:0];
        REG_FIXED:     fixed_r     <= cfg_data[0];
        REG_BLINK_ON:  blink_on_r  <= cfg_data[BLINK_W-1:0];
        REG_BLINK_OFF: blink_off_r <= cfg_data[BLINK_W-1:0];
        REG_DIT: begin
          dit_r  <= cfg_dit;
          dah_r  <= {1'b0, cfg_dit, 1'b0} + DAH_W'(cfg_dit);
          dit4_r <= {cfg_dit, 2'b00};
          dit7_r <= {cfg_dit, 3'b000} - DIT7_W'(cfg_dit);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r        <= '0;
      led_r       <= 1'b0;
      on_mark_r   <= '0;
      off_mark_r  <= '0;
      pat_r       <= '0;
      sl_r        <= '0;
      cnt_r       <= '0;
      rp_r        <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tc_r       <= tc_nxt;
      led_r      <= led_nxt;
      on_mark_r  <= on_mark_nxt;
      off_mark_r <= off_mark_nxt;
      pat_r      <= pat_nxt;
      sl_r       <= sl_nxt;
      cnt_r      <= cnt_nxt;
      rp_r       <= rp_nxt;
      wp_r       <= wp_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_led_r <= led_nxt;
      out_pos_r <= wp_ext[POS_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_led_on        = out_led_r;
  assign out_char_position = out_pos_r;

endmodule

FILE: sv/lbm_checker.sv
// Port-level checker for the LED keyer, bound to the top level
`include "led_blink_morse_driver_core_assert.svh"

module lbm_checker
  import lbm_pkg::*;
#(
  parameter int MSG_DEPTH = MSG_DEPTH_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_kind,
  input logic             in_last_char,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_led_on,
  input logic [POS_W-1:0] out_char_position
);

  logic           in_fire;
  logic           msg_end;
  logic           rewound;
  logic           pos_ok;
  logic           out_stall;
  logic [POS_W:0] out_word;

  assign in_fire   = in_valid && in_ready;
  assign msg_end   = in_fire && in_kind && in_last_char;
  assign rewound   = out_valid && (out_char_position == '0);
  assign pos_ok    = (MSG_DEPTH > 127) || (out_char_position <= POS_W'(MSG_DEPTH));
  assign out_stall = out_valid && !out_ready;
  assign out_word  = {out_led_on, out_char_position};

  `LBM_ASSERT(a_result_follows, in_fire |=> out_valid, "transaction gave no result")
  `LBM_ASSERT(a_msg_end_rewinds, msg_end |=> rewound, "message end did not rewind load position")
  `LBM_ASSERT(a_pos_in_range, out_valid |-> pos_ok, "load position beyond store depth")
  `LBM_ASSERT(a_out_hold, out_stall |=> (out_valid && $stable(out_word)), "stalled result changed")
  `LBM_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind led_blink_morse_driver_core lbm_checker #(.MSG_DEPTH(MSG_DEPTH)) u_lbm_checker (.*);
